### hw/rtl/itrd_pkg.sv
// itrd_pkg: item types, radix limits and the digit symbol map used by the
// radix conversion block.
// No dependencies.
package itrd_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned RADIX_W = 6;
  localparam int unsigned CHAR_W  = 7;

  localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;

  localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;  // '-'
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;  // '0'
  localparam logic [CHAR_W-1:0] CHAR_ALPHA = 7'h57;  // 'a' minus ten

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [RADIX_W-1:0]        radix;
  } in_item_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              last_char;
    logic              bad_base;
  } out_item_t;

  // Map a digit 0..35 to lowercase ASCII 0-9a-z.
  function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
    logic [CHAR_W-1:0] d_ext;
    d_ext = CHAR_W'(d);
    if (d < 6'd10) begin
      return CHAR_W'(CHAR_ZERO + d_ext);
    end
    return CHAR_W'(CHAR_ALPHA + d_ext);
  endfunction

endpackage

### hw/rtl/itrd_ram.sv
// itrd_ram: generic single write port, single read port RAM with registered
// read data. No package dependencies.
module itrd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/integer_to_radix_digits.sv
// integer_to_radix_digits: converts a signed integer to its ASCII text in a
// base of 2..36, one character per result, most significant first.
// Depends on itrd_pkg and itrd_ram.
//
//  Channel   Handshake                 Payload
//  --------  ------------------------  -----------------------------------
//  input     start & !busy accepts     item_i  (value, radix)
//  result    result_valid_o, 1 cycle   result_o (char_code, last_char,
//                                               bad_base)
//
// Each digit costs one restoring division by the radix on the shared
// one-bit-per-cycle subtract/compare unit. The digits land in a small RAM
// and are read back most significant first, each character by a RAM read,
// then an emit, after a '-' sign for a negative value. A bad radix gives
// its single result on the cycle after accept.
// Reset clears the sequencer and the result strobe; the RAM needs no clear.
// The receiver cannot stall: each result is shown for exactly one cycle.
module integer_to_radix_digits #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  itrd_pkg::in_item_t  item_i,
  output logic                result_valid_o,
  output itrd_pkg::out_item_t result_o
);

  import itrd_pkg::*;

  localparam int unsigned EXT_W = (VALUE_BITS > VALUE_W) ? VALUE_BITS : VALUE_W;
  localparam int unsigned AW    = $clog2(VALUE_BITS);
  localparam int unsigned BW    = $clog2(VALUE_BITS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SIGN,
    ST_FETCH,
    ST_EMIT
  } state_e;

  state_e                   state_q;
  logic [VALUE_BITS-1:0]    mag_q;      // dividend, becomes quotient in place
  logic [RADIX_W-1:0]       rem_q;      // partial remainder
  logic [RADIX_W-1:0]       radix_q;
  logic [BW-1:0]            bit_cnt_q;
  logic [AW-1:0]            idx_q;      // digit slot being written / read
  logic                     neg_q;
  logic                     out_valid_q;
  out_item_t                result_q;

  // Input decode.
  logic signed [EXT_W-1:0]  value_ext;
  logic [VALUE_BITS-1:0]    raw;
  logic                     raw_neg;
  logic [VALUE_BITS-1:0]    raw_mag;
  logic                     radix_bad;
  logic                     accept;

  assign value_ext = EXT_W'(item_i.value);
  assign raw       = value_ext[VALUE_BITS-1:0];
  assign raw_neg   = raw[VALUE_BITS-1];
  assign raw_mag   = raw_neg ? VALUE_BITS'(~raw + 1'b1) : raw;
  assign radix_bad = (item_i.radix < RADIX_MIN) || (item_i.radix > RADIX_MAX);
  assign accept    = start && (state_q == ST_IDLE);

  // Shared divide step: shift in the next dividend bit, trial subtract.
  logic [RADIX_W:0]         trial;
  logic [RADIX_W:0]         diff;
  logic                     q_bit;
  logic [RADIX_W-1:0]       rem_next;
  logic [VALUE_BITS-1:0]    quot_next;
  logic                     div_last;

  assign trial     = {rem_q, mag_q[VALUE_BITS-1]};
  assign diff      = trial - {1'b0, radix_q};
  assign q_bit     = (trial >= {1'b0, radix_q});
  assign rem_next  = q_bit ? diff[RADIX_W-1:0] : trial[RADIX_W-1:0];
  assign quot_next = {mag_q[VALUE_BITS-2:0], q_bit};
  assign div_last  = (bit_cnt_q == BW'(VALUE_BITS - 1));

  // Digit store: written once per finished division, read during emit.
  logic              ram_we;
  logic [RADIX_W-1:0] ram_rdata;

  assign ram_we = (state_q == ST_DIV) && div_last;

  itrd_ram #(
    .WIDTH (RADIX_W),
    .DEPTH (VALUE_BITS)
  ) u_digit_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_q),
    .wdata_i (rem_next),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mag_q       <= '0;
      rem_q       <= '0;
      radix_q     <= '0;
      bit_cnt_q   <= '0;
      idx_q       <= '0;
      neg_q       <= 1'b0;
      out_valid_q <= 1'b0;
      result_q    <= '0;
    end else begin
      out_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            if (radix_bad) begin
              // Empty string: one flagged result, stay idle.
              out_valid_q        <= 1'b1;
              result_q.char_code <= '0;
              result_q.last_char <= 1'b1;
              result_q.bad_base  <= 1'b1;
            end else begin
              mag_q     <= raw_mag;
              rem_q     <= '0;
              radix_q   <= item_i.radix;
              bit_cnt_q <= '0;
              idx_q     <= '0;
              neg_q     <= raw_neg;
              state_q   <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          if (div_last) begin
            // Digit goes to the RAM this cycle; advance or finish.
            mag_q     <= quot_next;
            rem_q     <= '0;
            bit_cnt_q <= '0;
            if (quot_next == '0) begin
              state_q <= neg_q ? ST_SIGN : ST_FETCH;
            end else begin
              idx_q <= idx_q + 1'b1;
            end
          end else begin
            mag_q     <= quot_next;
            rem_q     <= rem_next;
            bit_cnt_q <= bit_cnt_q + 1'b1;
          end
        end
        ST_SIGN: begin
          out_valid_q        <= 1'b1;
          result_q.char_code <= CHAR_MINUS;
          result_q.last_char <= 1'b0;
          result_q.bad_base  <= 1'b0;
          state_q            <= ST_FETCH;
        end
        ST_FETCH: begin
          // RAM read of slot idx_q is in flight.
          state_q <= ST_EMIT;
        end
        ST_EMIT: begin
          out_valid_q        <= 1'b1;
          result_q.char_code <= digit_char(ram_rdata);
          result_q.last_char <= (idx_q == '0);
          result_q.bad_base  <= 1'b0;
          if (idx_q == '0) begin
            state_q <= ST_IDLE;
          end else begin
            idx_q   <= idx_q - 1'b1;
            state_q <= ST_FETCH;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy           = (state_q != ST_IDLE);
  assign result_valid_o = out_valid_q;
  assign result_o       = result_q;

endmodule
